### hdl/stc_pkg.sv
// stc_pkg: shared constants, types and segment lookup for the thermometer core
// no dependencies; imported by stc_convert, stc_checker and the top level
package stc_pkg;

  // valid sensor count range is 0..SensorMax
  localparam int SensorMax = 28800;
  localparam int COffset   = -450;
  localparam int FOffset   = 320;

  // segment patterns for the error display
  localparam logic [6:0] SegE = 7'b0110111;
  localparam logic [6:0] SegR = 7'b1011111;

  // bit positions inside the display word
  localparam int DigitW      = 7;
  localparam int WordW       = 30;
  localparam int MinusLowBit = 16;
  localparam int MinusHiBit  = 23;
  localparam int CBit        = 28;
  localparam int FBit        = 29;

  // reciprocal constants for constant division
  localparam int Recip5Mul    = 6554;   // >> 15 gives x/5 for x < 4096
  localparam int Recip5Shift  = 15;
  localparam int Recip10Mul   = 6554;   // >> 16 gives x/10 for x < 1638
  localparam int Recip10Shift = 16;
  localparam int Recip100Mul  = 5243;   // >> 19 gives x/100 for x < 2048
  localparam int Recip100Shift = 19;

  // temperature in tenths of a degree, after conversion: -490..1130
  localparam int TempW = 12;

  // control flags that travel with a beat through the conversion stages
  typedef struct packed {
    logic valid;
    logic err;
    logic fahr;
  } conv_ctl_t;

  // decimal digit to seven-segment pattern
  function automatic logic [6:0] seg_digit(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b1111011;
      4'd1:    s = 7'b1001000;
      4'd2:    s = 7'b0111101;
      4'd3:    s = 7'b1101101;
      4'd4:    s = 7'b1001110;
      4'd5:    s = 7'b1100111;
      4'd6:    s = 7'b1110111;
      4'd7:    s = 7'b1001001;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

### hdl/stc_convert.sv
// stc_convert: range check, rounding, offset and optional Fahrenheit conversion
// two register stages; depends on stc_pkg
module stc_convert
  import stc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [15:0]      reading,
  input  logic [7:0]              status,
  output conv_ctl_t               ctl,
  output logic signed [TempW-1:0] temp
);

  // stage a: validity, round half up, offset, times nine in F mode
  logic              a_err_next;
  logic [9:0]        a_round;
  logic signed [10:0] a_cel;
  logic signed [12:0] a_prod_next;
  conv_ctl_t         a_ctl;
  logic signed [12:0] a_prod;

  always_comb begin
    a_err_next = reading[15] || (reading > 16'sd28800) || status[2];
    a_round    = 10'((17'(unsigned'(reading)) + 17'd16) >> 5);
    a_cel      = $signed({1'b0, a_round}) + 11'(COffset);
    if (status[5]) begin
      a_prod_next = 13'(a_cel) * 13'sd9;
    end else begin
      a_prod_next = 13'(a_cel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.valid <= 1'b0;
    end else begin
      a_ctl.valid <= in_valid;
    end
    a_ctl.err  <= a_err_next;
    a_ctl.fahr <= status[5];
    a_prod     <= a_prod_next;
  end

  // stage b: in F mode divide by five toward zero on the magnitude and add the F offset; in C mode pass through
  logic        b_neg;
  logic [11:0] b_mag;
  logic [24:0] b_scaled;
  logic [9:0]  b_quot;
  logic signed [TempW-1:0] b_div;
  logic signed [TempW-1:0] temp_next;

  always_comb begin
    b_neg    = a_prod[12];
    b_mag    = b_neg ? 12'(-a_prod) : 12'(a_prod);
    b_scaled = 25'(b_mag) * 25'(Recip5Mul);
    b_quot   = 10'(b_scaled >> Recip5Shift);
    b_div    = b_neg ? -$signed({2'b00, b_quot}) : $signed({2'b00, b_quot});
    if (a_ctl.fahr) begin
      temp_next = b_div + TempW'(FOffset);
    end else begin
      temp_next = TempW'(a_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= a_ctl.valid;
    end
    ctl.err  <= a_ctl.err;
    ctl.fahr <= a_ctl.fahr;
    temp     <= temp_next;
  end

endmodule

### hdl/sensor_to_seven_segment_thermometer_core.sv
// sensor_to_seven_segment_thermometer_core: top level of the display core
// holds the input and result registers and the digit encoder; uses stc_pkg, stc_convert
//
// Usage: drive sensor_reading and status_bits with start high for one cycle per beat.
// A beat is taken at each rising edge with start high and busy low; busy is always low,
// so a new reading can be taken in every cycle and the sustained rate is one per cycle.
// Each beat yields exactly one result: display_word and error_flag are valid for the
// single cycle in which done is high, and the receiver takes it at the end of that
// cycle. The receiver cannot stall the block.
// Path: a beat passes the input register, two conversion stages and the result register,
// and done rises with its result.
// Results leave in the order readings came.
// A reading below 0 or above 28800, or status bit 2 set, shows ERR with error_flag set.
// Otherwise the value is shown in tenths of a degree, C or F by status bit 5.
// Reset (rst, synchronous) clears all valid bits; no beat in flight survives it.
module sensor_to_seven_segment_thermometer_core
  import stc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sensor_reading,
  input  logic [7:0]         status_bits,
  output logic               done,
  output logic [WordW-1:0]   display_word,
  output logic               error_flag
);

  // block never holds off a beat
  assign busy = 1'b0;

  // input register
  logic              in_valid;
  logic signed [15:0] in_reading;
  logic [7:0]        in_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_reading <= sensor_reading;
    in_status  <= status_bits;
  end

  // conversion stages
  conv_ctl_t               cv_ctl;
  logic signed [TempW-1:0] cv_temp;

  stc_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .reading  (in_reading),
    .status   (in_status),
    .ctl      (cv_ctl),
    .temp     (cv_temp)
  );

  // digit split by reciprocal multiplies
  logic        neg;
  logic [10:0] mag;
  logic [26:0] q1_prod;
  logic [22:0] q2_prod;
  logic [6:0]  q1;
  logic [3:0]  tens;
  logic [3:0]  tenths;
  logic [3:0]  ones;

  always_comb begin
    neg     = cv_temp[TempW-1];
    mag     = neg ? 11'(-cv_temp) : 11'(cv_temp);
    q1_prod = 27'(mag) * 27'(Recip10Mul);
    q2_prod = 23'(mag) * 23'(Recip100Mul);
    q1      = 7'(q1_prod >> Recip10Shift);
    tens    = 4'(q2_prod >> Recip100Shift);
    tenths  = 4'(mag - 11'({q1, 3'b000}) - 11'({q1, 1'b0}));
    ones    = 4'(q1 - 7'({tens, 3'b000}) - 7'({tens, 1'b0}));
  end

  // segment word assembly
  logic [WordW-1:0] word_next;
  logic [3:0]       tens_low;

  always_comb begin
    tens_low  = (tens >= 4'd10) ? 4'(tens - 4'd10) : tens;
    word_next = '0;
    if (cv_ctl.err) begin
      word_next[3*DigitW +: DigitW] = SegE;
      word_next[2*DigitW +: DigitW] = SegR;
      word_next[1*DigitW +: DigitW] = SegR;
    end else begin
      word_next[cv_ctl.fahr ? FBit : CBit] = 1'b1;
      word_next[0 +: DigitW]      = seg_digit(tenths);
      word_next[DigitW +: DigitW] = seg_digit(ones);
      if (tens != 4'd0) begin
        word_next[2*DigitW +: DigitW] = seg_digit(tens_low);
        if (tens >= 4'd10) begin
          word_next[3*DigitW +: DigitW] = seg_digit(4'd1);
        end else if (neg) begin
          word_next[MinusHiBit] = 1'b1;
        end
      end else if (neg) begin
        word_next[MinusLowBit] = 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv_ctl.valid;
    end
    display_word <= word_next;
    error_flag   <= cv_ctl.err;
  end

endmodule

### hdl/stc_checker.sv
// stc_checker: port-level checks for the thermometer core over time
// depends on stc_pkg; bound to sensor_to_seven_segment_thermometer_core below
module stc_checker
  import stc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] sensor_reading,
  input logic [7:0]         status_bits,
  input logic               done,
  input logic [WordW-1:0]   display_word,
  input logic               error_flag
);

  // every accepted beat is followed by a result with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result missing four cycles after an accepted beat");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching beat");

  // a sensor error beat shows ERR with the flag set
  a_sensor_err: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && status_bits[2]) |-> ##4
      (error_flag && display_word ==
        {2'b00, SegE, SegR, SegR, {DigitW{1'b0}}}))
    else $error("sensor error beat did not show ERR");

  // an out-of-range reading raises the error flag
  a_range: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (sensor_reading < 0 || sensor_reading > SensorMax)) |-> ##4
      error_flag)
    else $error("out-of-range reading without the error flag");

  // a good result carries exactly one unit indicator
  a_unit: assert property (@(posedge clk) disable iff (rst)
    (done && !error_flag) |-> (display_word[FBit] ^ display_word[CBit]))
    else $error("good result without exactly one unit indicator");

endmodule

bind sensor_to_seven_segment_thermometer_core stc_checker u_stc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .sensor_reading (sensor_reading),
  .status_bits    (status_bits),
  .done           (done),
  .display_word   (display_word),
  .error_flag     (error_flag)
);
